// ===== src/image_header_check_and_copy_unit_defines.svh =====
// Assertion macros shared by the image header check and copy RTL.
`ifndef IMAGE_HEADER_CHECK_AND_COPY_UNIT_DEFINES_SVH
`define IMAGE_HEADER_CHECK_AND_COPY_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while rst is high.
`define IHC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst is high.
`define IHC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ihc_pkg.sv =====
// Shared types and constants for the image header check and copy unit.
`default_nettype none
package ihc_pkg;

  localparam int unsigned HDR_BYTES = 16;
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
  localparam logic [47:0] CODE_BASE_RESET = 48'h0080_0000_0000;

  // load status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
  localparam logic [2:0] ST_BAD_HDR   = 3'd2;
  localparam logic [2:0] ST_BAD_CODE  = 3'd3;
  localparam logic [2:0] ST_BAD_ENTRY = 3'd4;
  localparam logic [2:0] ST_TRUNC     = 3'd5;

  // result kinds
  localparam logic RK_WRITE  = 1'b0;
  localparam logic RK_STATUS = 1'b1;

  // One parsed byte: an optional page write and, on the last byte, a header snapshot.
  typedef struct packed {
    logic        wr;
    logic        fin;
    logic [11:0] wr_off;
    logic [7:0]  wr_byte;
    logic [31:0] size;
    logic        magic_ok;
    logic [15:0] hdr_len;
    logic [15:0] entry_off;
    logic [31:0] code_len;
  } item_t;

  function automatic logic [7:0] magic_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0: c = 8'h41;
      2'd1: c = 8'h57;
      2'd2: c = 8'h50;
      2'd3: c = 8'h31;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== src/ihc_parse.sv =====
// Header field capture, byte counter and page write decision, with the input stage register.
`default_nettype none
module ihc_parse import ihc_pkg::*; #(
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  input  wire logic       item_take,
  output logic            item_valid,
  output item_t           item
);

  localparam logic [31:0] PAGE_LIM = 32'(PAGE_BYTES);

  logic [31:0] byte_count, byte_count_next;
  logic        magic_good, magic_good_next;
  logic [15:0] header_length, header_length_next;
  logic [15:0] entry_offset_field, entry_offset_field_next;
  logic [31:0] code_length, code_length_next;
  logic [31:0] off;
  logic        wr;
  logic        fire;

  assign in_ready = !item_valid || item_take;
  assign fire     = in_valid && in_ready;

  always_comb begin
    magic_good_next         = magic_good;
    header_length_next      = header_length;
    entry_offset_field_next = entry_offset_field;
    code_length_next        = code_length;
    if (byte_count < 32'd4) begin
      if (in_byte != magic_char(byte_count[1:0])) magic_good_next = 1'b0;
    end else if (byte_count == 32'd4) begin
      header_length_next[7:0] = in_byte;
    end else if (byte_count == 32'd5) begin
      header_length_next[15:8] = in_byte;
    end else if (byte_count == 32'd6) begin
      entry_offset_field_next[7:0] = in_byte;
    end else if (byte_count == 32'd7) begin
      entry_offset_field_next[15:8] = in_byte;
    end else if (byte_count inside {[32'd8:32'd11]}) begin
      case (byte_count[1:0])
        2'd0: code_length_next[7:0]   = in_byte;
        2'd1: code_length_next[15:8]  = in_byte;
        2'd2: code_length_next[23:16] = in_byte;
        2'd3: code_length_next[31:24] = in_byte;
        default: code_length_next = code_length;
      endcase
    end
    byte_count_next = (byte_count == COUNT_MAX) ? byte_count : byte_count + 32'd1;
  end

  // header is complete from byte 16 on, so the stored length is final here
  assign off = byte_count - {16'd0, header_length};
  assign wr  = (byte_count >= 32'(HDR_BYTES)) && (byte_count >= {16'd0, header_length}) &&
               (off < code_length) && (off < PAGE_LIM);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count         <= '0;
      magic_good         <= 1'b1;
      header_length      <= '0;
      entry_offset_field <= '0;
      code_length        <= '0;
      item_valid         <= 1'b0;
    end else begin
      if (fire) begin
        item_valid <= 1'b1;
        if (in_last) begin
          byte_count         <= '0;
          magic_good         <= 1'b1;
          header_length      <= '0;
          entry_offset_field <= '0;
          code_length        <= '0;
        end else begin
          byte_count         <= byte_count_next;
          magic_good         <= magic_good_next;
          header_length      <= header_length_next;
          entry_offset_field <= entry_offset_field_next;
          code_length        <= code_length_next;
        end
      end else if (item_take) begin
        item_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      item.wr        <= wr;
      item.fin       <= in_last;
      item.wr_off    <= off[11:0];
      item.wr_byte   <= in_byte;
      item.size      <= byte_count_next;
      item.magic_ok  <= magic_good_next;
      item.hdr_len   <= header_length_next;
      item.entry_off <= entry_offset_field_next;
      item.code_len  <= code_length_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/ihc_result.sv =====
// Status check, entry point add and result register that sends a write and a status in turn.
`default_nettype none
module ihc_result import ihc_pkg::*; #(
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [47:0] code_base,
  input  wire logic        item_valid,
  output logic             item_take,
  input  wire item_t       item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_kind,
  output logic [11:0]      out_offset,
  output logic [7:0]       out_byte,
  output logic [2:0]       out_status,
  output logic [47:0]      out_addr,
  output logic             out_final
);

  localparam logic [31:0] PAGE_LIM = 32'(PAGE_BYTES);

  logic        wr_pend, st_pend;
  logic [11:0] wr_off;
  logic [7:0]  wr_byte;
  logic [2:0]  status;
  logic [47:0] entry_addr;
  logic [2:0]  status_next;
  logic [47:0] sum;
  logic        out_fire, drained, ready_up;

  always_comb begin
    if (item.size < 32'(HDR_BYTES) || !item.magic_ok) begin
      status_next = ST_BAD_MAGIC;
    end else if (item.hdr_len < 16'(HDR_BYTES) || {16'd0, item.hdr_len} > item.size) begin
      status_next = ST_BAD_HDR;
    end else if (item.code_len == 32'd0 || item.code_len > PAGE_LIM) begin
      status_next = ST_BAD_CODE;
    end else if ({16'd0, item.entry_off} >= item.code_len) begin
      status_next = ST_BAD_ENTRY;
    end else if (item.size - {16'd0, item.hdr_len} < item.code_len) begin
      status_next = ST_TRUNC;
    end else begin
      status_next = ST_OK;
    end
  end

  assign sum = code_base + {32'd0, item.entry_off};

  assign out_valid = wr_pend || st_pend;
  assign out_fire  = out_valid && out_ready;
  // the write goes first when both are pending
  assign drained   = out_fire && !(wr_pend && st_pend);
  assign ready_up  = !out_valid || drained;
  assign item_take = item_valid && ready_up;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pend <= 1'b0;
      st_pend <= 1'b0;
    end else if (item_take) begin
      wr_pend <= item.wr;
      st_pend <= item.fin;
    end else if (out_fire) begin
      if (wr_pend) wr_pend <= 1'b0;
      else         st_pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      wr_off     <= item.wr_off;
      wr_byte    <= item.wr_byte;
      status     <= status_next;
      entry_addr <= (status_next == ST_OK) ? sum : '0;
    end
  end

  assign out_kind   = wr_pend ? RK_WRITE : RK_STATUS;
  assign out_offset = wr_pend ? wr_off : '0;
  assign out_byte   = wr_pend ? wr_byte : '0;
  assign out_status = wr_pend ? ST_OK : status;
  assign out_addr   = wr_pend ? '0 : entry_addr;
  assign out_final  = !wr_pend;

endmodule
`default_nettype wire

// ===== src/image_header_check_and_copy_unit.sv =====
// Top level of the image header check and copy unit.
//
//  channel     dir  tdata fields (low bit up)                     tuser        tlast
//  s_axis      in   image_byte[7:0]                               -            last_byte
//  m_axis      out  write_offset, write_byte, load_status,        result_kind  final_flag
//                   entry_address, one zero pad bit
//  code_base   in   write enable code_base_we, data code_base_wdata
//
// Takes one image byte per cycle while m_axis keeps up. An accepted byte goes through
// the input stage register and then the result register to m_axis. The last byte of
// an image with a code write gives two output requests, write first. The input and
// result registers keep taking bytes while m_axis stalls until both are full. rst clears
// the parse state and sets code_base to 0x0080_0000_0000.
`default_nettype none
`include "image_header_check_and_copy_unit_defines.svh"
module image_header_check_and_copy_unit import ihc_pkg::*; #(
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] image_byte
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [11:0] write_offset, [19:12] write_byte, [22:20] load_status,
  // [70:23] entry_address, [71] zero
  output logic [71:0]      m_axis_tdata,
  output logic             m_axis_tuser,   // [0] result_kind
  output logic             m_axis_tlast,
  input  wire logic        code_base_we,
  input  wire logic [47:0] code_base_wdata
);

  logic [47:0] code_base;
  logic        item_valid, item_take;
  item_t       item;
  logic [11:0] out_offset;
  logic [7:0]  out_byte;
  logic [2:0]  out_status;
  logic [47:0] out_addr;

  always_ff @(posedge clk) begin
    if (rst) code_base <= CODE_BASE_RESET;
    else if (code_base_we) code_base <= code_base_wdata;
  end

  ihc_parse #(.PAGE_BYTES(PAGE_BYTES)) u_parse (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .in_last    (s_axis_tlast),
    .item_take  (item_take),
    .item_valid (item_valid),
    .item       (item)
  );

  ihc_result #(.PAGE_BYTES(PAGE_BYTES)) u_result (
    .clk        (clk),
    .rst        (rst),
    .code_base  (code_base),
    .item_valid (item_valid),
    .item_take  (item_take),
    .item       (item),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_kind   (m_axis_tuser),
    .out_offset (out_offset),
    .out_byte   (out_byte),
    .out_status (out_status),
    .out_addr   (out_addr),
    .out_final  (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, out_addr, out_status, out_byte, out_offset};

  `IHC_ASSERT_NOW(a_write_no_status, m_axis_tvalid && m_axis_tuser == RK_WRITE,
    m_axis_tdata[70:20] == '0 && !m_axis_tlast, "write request carries status fields")
  `IHC_ASSERT_NOW(a_bad_status_no_addr,
    m_axis_tvalid && m_axis_tuser == RK_STATUS && m_axis_tdata[22:20] != ST_OK,
    m_axis_tdata[70:23] == '0, "entry address set on failed load")
  `IHC_ASSERT_NOW(a_stall_only_full, !s_axis_tready, item_valid && m_axis_tvalid,
    "input stalled with a free stage")
  `IHC_ASSERT_NEXT(a_hold_while_stalled, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast),
    "request changed while stalled")

endmodule
`default_nettype wire
